FILE: hw/rtl/rmc_pkg.sv
// Package for the rational add / multiply / compare unit.
// Widths, command codes, controller states and the controller-datapath structs.
// No dependencies.
package rmc_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int MW = 2 * OPERAND_WIDTH;   // magnitude / denominator width
    localparam int NW = MW + 1;              // numerator width
    localparam int KW = $clog2(MW + 1);      // gcd shift count width
    localparam int CW = $clog2(MW);          // divider step count width

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_MUL = 2'd1,
        CMD_CMP = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_AD_SET,
        MUL_CB_ADD,
        MUL_BD_DEN,
        MUL_AC_SET
    } t_mul_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_GINIT,
        S_GCD,
        S_GFIN,
        S_DIVN,
        S_DIVD,
        S_STORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic    load;
        t_mul_op mul_op;
        logic    gcd_init;
        logic    gcd_step;
        logic    gcd_fin;
        logic    div_step;
        logic    div_den;
        logic    save_first;
        logic    load_cd;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic       gcd_done;
        logic       g_zero;
        logic       div_last;
        logic       out_free;
    } t_dp_sts;

endpackage

FILE: hw/rtl/rational_add_mul_compare_unit.sv
// Rational add / multiply / compare unit: top level; depends on rmc_pkg, rmc_ctrl, rmc_dp.
// Latency accept to valid depends on the command and on the gcd loop steps of each reduction;
// a zero over zero reduction skips both divisions.
// One transaction at a time: next accept in the cycle after the result is loaded; a result not
// yet taken stalls only that load, and the waiting result is taken in the same cycle.
// Reset (synchronous, active low) returns the controller to idle and drops the output valid.
module rational_add_mul_compare_unit
    import rmc_pkg::*;
(
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_command,
    input  logic signed [OPERAND_WIDTH-1:0] i_first_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_first_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_second_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_second_den,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [NW-1:0]            o_result_num,
    output logic signed [MW-1:0]            o_result_den,
    output logic                            o_is_equal,
    output logic                            o_zero_gcd_error
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_dp_sts w_sts_ctrl;

    // the controller decodes the incoming command while idle
    always_comb begin
        w_sts_ctrl = w_sts;
        if (o_ready) begin
            w_sts_ctrl.command = i_command;
        end
    end

    rmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts_ctrl),
        .o_cmd   (w_cmd)
    );

    rmc_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_command        (i_command),
        .i_first_num      (i_first_num),
        .i_first_den      (i_first_den),
        .i_second_num     (i_second_num),
        .i_second_den     (i_second_den),
        .i_out_ready      (i_ready),
        .o_out_valid      (o_valid),
        .o_result_num     (o_result_num),
        .o_result_den     (o_result_den),
        .o_is_equal       (o_is_equal),
        .o_zero_gcd_error (o_zero_gcd_error)
    );

endmodule

FILE: hw/rtl/rmc_ctrl.sv
// Controller state machine for the rational add / multiply / compare unit.
// Sequences multiply, binary gcd and two serial divisions per reduction.
// Depends on rmc_pkg.
module rmc_ctrl
    import rmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                n_pass  = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_sts.command)
                        CMD_ADD, CMD_MUL: n_state = S_MUL1;
                        CMD_CMP:          n_state = S_GINIT;
                        default:          n_state = S_DONE;
                    endcase
                end
            end
            S_MUL1: begin
                if (i_sts.command == CMD_ADD) begin
                    o_cmd.mul_op = MUL_AD_SET;
                    n_state      = S_MUL2;
                end else begin
                    o_cmd.mul_op = MUL_AC_SET;
                    n_state      = S_MUL3;
                end
            end
            S_MUL2: begin
                o_cmd.mul_op = MUL_CB_ADD;
                n_state      = S_MUL3;
            end
            S_MUL3: begin
                o_cmd.mul_op = MUL_BD_DEN;
                n_state      = S_GINIT;
            end
            S_GINIT: begin
                o_cmd.gcd_init = 1'b1;
                n_state        = S_GCD;
            end
            S_GCD: begin
                if (i_sts.gcd_done) begin
                    n_state = S_GFIN;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_GFIN: begin
                o_cmd.gcd_fin = 1'b1;
                n_state       = i_sts.g_zero ? S_STORE : S_DIVN;
            end
            S_DIVN: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_den  = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                if (i_sts.command == CMD_CMP && !r_pass) begin
                    o_cmd.save_first = 1'b1;
                    o_cmd.load_cd    = 1'b1;
                    n_pass           = 1'b1;
                    n_state          = S_GINIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_gcd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD && !i_sts.gcd_done) |=> (r_state == S_GCD))
        else $error("gcd loop left early");

    a_div_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIVN && i_sts.div_last) |=> (r_state == S_DIVD))
        else $error("denominator division skipped");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_valid) |=> (r_state != S_IDLE))
        else $error("accepted transaction not started");

endmodule

FILE: hw/rtl/rmc_dp.sv
// Datapath for the rational add / multiply / compare unit.
// Operand registers, shared multiplier, binary gcd, restoring divider, output register.
// Depends on rmc_pkg.
module rmc_dp
    import rmc_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_dp_cmd                     i_cmd,
    output t_dp_sts                     o_sts,
    input  logic [1:0]                  i_command,
    input  logic signed [OPERAND_WIDTH-1:0] i_first_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_first_den,
    input  logic signed [OPERAND_WIDTH-1:0] i_second_num,
    input  logic signed [OPERAND_WIDTH-1:0] i_second_den,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic signed [NW-1:0]        o_result_num,
    output logic signed [MW-1:0]        o_result_den,
    output logic                        o_is_equal,
    output logic                        o_zero_gcd_error
);

    logic [1:0]                      r_cmd;
    logic signed [OPERAND_WIDTH-1:0] r_a, r_b, r_c, r_d;
    logic signed [NW-1:0]            r_n;
    logic signed [MW-1:0]            r_dn;
    logic [MW-1:0]                   r_u, r_v, r_g;
    logic [KW-1:0]                   r_k;
    logic [MW-1:0]                   r_rem, r_q;
    logic [CW-1:0]                   r_cnt;
    logic signed [NW-1:0]            r_qn, r_qn1;
    logic signed [MW-1:0]            r_qd, r_qd1;
    logic                            r_zero, r_zero1;
    logic signed [NW-1:0]            r_res_num;
    logic signed [MW-1:0]            r_res_den;
    logic                            r_res_eq, r_res_err;
    logic                            r_out_valid;

    logic signed [OPERAND_WIDTH-1:0] w_ma, w_mb;
    logic signed [MW-1:0]            w_prod;
    logic [NW-1:0]                   w_n_abs;
    logic [MW-1:0]                   w_n_mag, w_d_mag;
    logic [MW-1:0]                   n_u, n_v;
    logic [KW-1:0]                   n_k;
    logic [MW-1:0]                   w_uv, w_g;
    logic [MW:0]                     w_trial;
    logic                            w_fit;
    logic [MW:0]                     w_diff;
    logic [MW-1:0]                   w_rem_next, w_q_next;
    logic signed [NW-1:0]            w_qn_signed;
    logic signed [MW-1:0]            w_qd_signed;
    logic                            w_div_last;
    logic                            w_cmp_err;
    logic signed [NW-1:0]            w_out_num;
    logic signed [MW-1:0]            w_out_den;
    logic                            w_out_eq, w_out_err;

    always_comb begin
        case (i_cmd.mul_op)
            MUL_CB_ADD: begin w_ma = r_c; w_mb = r_b; end
            MUL_BD_DEN: begin w_ma = r_b; w_mb = r_d; end
            MUL_AC_SET: begin w_ma = r_a; w_mb = r_c; end
            default:    begin w_ma = r_a; w_mb = r_d; end
        endcase
    end

    assign w_prod  = w_ma * w_mb;
    assign w_n_abs = r_n[NW-1] ? (~r_n + 1'b1) : r_n;
    assign w_n_mag = w_n_abs[MW-1:0];
    assign w_d_mag = r_dn[MW-1] ? (~r_dn + 1'b1) : r_dn;

    // binary gcd step
    always_comb begin
        n_u = r_u;
        n_v = r_v;
        n_k = r_k;
        if (r_u != '0 && r_v != '0) begin
            if (!r_u[0] && !r_v[0]) begin
                n_u = r_u >> 1;
                n_v = r_v >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_u[0]) begin
                n_u = r_u >> 1;
            end else if (!r_v[0]) begin
                n_v = r_v >> 1;
            end else if (r_u >= r_v) begin
                n_u = r_u - r_v;
            end else begin
                n_v = r_v - r_u;
            end
        end
    end

    assign w_uv = r_u | r_v;
    assign w_g  = w_uv << r_k;

    // restoring divider step
    assign w_trial    = {r_rem, r_q[MW-1]};
    assign w_fit      = w_trial >= {1'b0, r_g};
    assign w_diff     = w_trial - {1'b0, r_g};
    assign w_rem_next = w_fit ? w_diff[MW-1:0] : w_trial[MW-1:0];
    assign w_q_next   = {r_q[MW-2:0], w_fit};
    assign w_div_last = (r_cnt == CW'(MW - 1));

    assign w_qn_signed = r_n[NW-1] ? (NW'(0) - {1'b0, w_q_next}) : {1'b0, w_q_next};
    assign w_qd_signed = r_dn[MW-1] ? (MW'(0) - w_q_next) : w_q_next;

    assign w_cmp_err = r_zero | r_zero1;

    always_comb begin
        w_out_num = '0;
        w_out_den = '0;
        w_out_eq  = 1'b0;
        w_out_err = 1'b0;
        case (r_cmd)
            CMD_ADD, CMD_MUL: begin
                w_out_num = r_qn;
                w_out_den = r_qd;
                w_out_err = r_zero;
            end
            CMD_CMP: begin
                w_out_err = w_cmp_err;
                w_out_eq  = !w_cmp_err && (r_qn1 == r_qn) && (r_qd1 == r_qd);
            end
            default: begin
                w_out_err = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_a   <= i_first_num;
            r_b   <= i_first_den;
            r_c   <= i_second_num;
            r_d   <= i_second_den;
            r_n   <= NW'(i_first_num);
            r_dn  <= MW'(i_first_den);
        end
        case (i_cmd.mul_op)
            MUL_AD_SET, MUL_AC_SET: r_n  <= NW'(w_prod);
            MUL_CB_ADD:             r_n  <= r_n + NW'(w_prod);
            MUL_BD_DEN:             r_dn <= w_prod;
            default: begin
            end
        endcase
        if (i_cmd.load_cd) begin
            r_n  <= NW'(r_c);
            r_dn <= MW'(r_d);
        end
        if (i_cmd.gcd_init) begin
            r_u <= w_n_mag;
            r_v <= w_d_mag;
            r_k <= '0;
        end
        if (i_cmd.gcd_step) begin
            r_u <= n_u;
            r_v <= n_v;
            r_k <= n_k;
        end
        if (i_cmd.gcd_fin) begin
            r_g    <= w_g;
            r_zero <= (w_uv == '0);
            r_qn   <= '0;
            r_qd   <= '0;
            r_rem  <= '0;
            r_q    <= w_n_mag;
            r_cnt  <= '0;
        end
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (w_div_last && !i_cmd.div_den) begin
                r_qn  <= w_qn_signed;
                r_rem <= '0;
                r_q   <= w_d_mag;
            end else begin
                r_rem <= w_rem_next;
                r_q   <= w_q_next;
                if (w_div_last) begin
                    r_qd <= w_qd_signed;
                end
            end
        end
        if (i_cmd.save_first) begin
            r_qn1   <= r_qn;
            r_qd1   <= r_qd;
            r_zero1 <= r_zero;
        end
        if (i_cmd.out_load) begin
            r_res_num <= w_out_num;
            r_res_den <= w_out_den;
            r_res_eq  <= w_out_eq;
            r_res_err <= w_out_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.command  = r_cmd;
    assign o_sts.gcd_done = (r_u == '0) || (r_v == '0);
    assign o_sts.g_zero   = (w_uv == '0);
    assign o_sts.div_last = w_div_last;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_result_num     = r_res_num;
    assign o_result_den     = r_res_den;
    assign o_is_equal       = r_res_eq;
    assign o_zero_gcd_error = r_res_err;

    a_out_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("result register not marked valid");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_g))
        else $error("divider remainder not below gcd");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_res_num)
            && $stable(r_res_den) && $stable(r_res_eq) && $stable(r_res_err)))
        else $error("waiting result changed");

endmodule

FILE: tb/sv/tb_rational_add_mul_compare_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for rational_add_mul_compare_unit: directed table, then random traffic.
// Expected results come from the directed table or an in-bench fraction reducer; depends on rmc_pkg and the RTL.
module tb_rational_add_mul_compare_unit;
    import rmc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [1:0]               cmd;
        logic signed [OPERAND_WIDTH-1:0] a, b, c, d;
        bit                       fixed;
        logic signed [NW-1:0]     num;
        logic signed [MW-1:0]     den;
        logic                     eq, err;
    } t_row;

    typedef struct {
        logic signed [NW-1:0] num;
        logic signed [MW-1:0] den;
        logic                 eq, err;
    } t_frac_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic [1:0] i_command = '0;
    logic signed [OPERAND_WIDTH-1:0] i_first_num = '0, i_first_den = '0;
    logic signed [OPERAND_WIDTH-1:0] i_second_num = '0, i_second_den = '0;
    logic o_ready, o_valid, o_is_equal, o_zero_gcd_error;
    logic signed [NW-1:0] o_result_num;
    logic signed [MW-1:0] o_result_den;

    t_frac_res pending_results[$];
    t_row      directed_rows[$];
    int        fail_count = 0;
    int        tx_idle = 38, rx_idle = 69;
    longint    cycle_count = 0;

    rational_add_mul_compare_unit uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // reduce n/d by gcd of magnitudes, signs kept in place
    function automatic bit reduce_frac(longint n, longint d, output longint rn, output longint rd);
        longint unsigned x, y, t;
        x = abs64(n);
        y = abs64(d);
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        if (x == 0) begin
            rn = 0;
            rd = 0;
            return 1'b0;
        end
        rn = (n < 0) ? -longint'(abs64(n) / x) : longint'(abs64(n) / x);
        rd = (d < 0) ? -longint'(abs64(d) / x) : longint'(abs64(d) / x);
        return 1'b1;
    endfunction

    function automatic t_frac_res predict_fraction(t_row r);
        t_frac_res res;
        longint a, b, c, d, n, rn, rd, n1, d1, n2, d2;
        bit ok1, ok2;
        a = r.a; b = r.b; c = r.c; d = r.d;
        res = '{num: '0, den: '0, eq: 1'b0, err: 1'b0};
        if (r.cmd == CMD_ADD || r.cmd == CMD_MUL) begin
            n = (r.cmd == CMD_ADD) ? a * d + c * b : a * c;
            res.err = !reduce_frac(n, b * d, rn, rd);
            res.num = rn[NW-1:0];
            res.den = rd[MW-1:0];
        end else if (r.cmd == CMD_CMP) begin
            ok1 = reduce_frac(a, b, n1, d1);
            ok2 = reduce_frac(c, d, n2, d2);
            res.err = !(ok1 && ok2);
            res.eq = ok1 && ok2 && n1 == n2 && d1 == d2;
        end
        return res;
    endfunction

    task automatic send_transaction(t_row r);
        t_frac_res res;
        if ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle);
        end
        i_valid      <= 1'b1;
        i_command    <= r.cmd;
        i_first_num  <= r.a;
        i_first_den  <= r.b;
        i_second_num <= r.c;
        i_second_den <= r.d;
        do @(posedge i_clk); while (!o_ready);
        if (r.fixed) res = '{num: r.num, den: r.den, eq: r.eq, err: r.err};
        else res = predict_fraction(r);
        pending_results.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_frac_res e;
        i_ready <= i_rst_n && ($urandom_range(99) >= rx_idle);
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result num=%0d den=%0d", o_result_num, o_result_den);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_result_num !== e.num) begin
                    $error("result_num exp %0d act %0d", e.num, o_result_num);
                    fail_count++;
                end
                if (o_result_den !== e.den) begin
                    $error("result_den exp %0d act %0d", e.den, o_result_den);
                    fail_count++;
                end
                if (o_is_equal !== e.eq) begin
                    $error("is_equal exp %0b act %0b", e.eq, o_is_equal);
                    fail_count++;
                end
                if (o_zero_gcd_error !== e.err) begin
                    $error("zero_gcd_error exp %0b act %0b", e.err, o_zero_gcd_error);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic signed [OPERAND_WIDTH-1:0] rand_operand();
        case ($urandom_range(5))
            0: return '0;
            1, 2: return OPERAND_WIDTH'($signed(OPERAND_WIDTH'($urandom_range(24)))
                                        * ($urandom_range(1) ? 1 : -1));
            3: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
            default: return OPERAND_WIDTH'($urandom);
        endcase
    endfunction

    function automatic t_row mk(logic [1:0] cmd, int a, int b, int c, int d);
        t_row r;
        r = '{cmd: cmd, a: OPERAND_WIDTH'(a), b: OPERAND_WIDTH'(b), c: OPERAND_WIDTH'(c),
              d: OPERAND_WIDTH'(d), fixed: 1'b0, num: '0, den: '0, eq: 1'b0, err: 1'b0};
        return r;
    endfunction

    function automatic t_row mk_fixed(logic [1:0] cmd, int a, int b, int c, int d,
                                      longint num, longint den, bit eq, bit err);
        t_row r;
        r = mk(cmd, a, b, c, d);
        r.fixed = 1'b1;
        r.num = num[NW-1:0];
        r.den = den[MW-1:0];
        r.eq = eq;
        r.err = err;
        return r;
    endfunction

    initial begin
        t_row r;
        directed_rows.push_back(mk_fixed(CMD_ADD, 0, 0, 0, 0, 0, 0, 0, 1));
        directed_rows.push_back(mk_fixed(CMD_MUL, 0, 0, 0, 0, 0, 0, 0, 1));
        directed_rows.push_back(mk_fixed(CMD_MUL, 0, 5, 3, 0, 0, 0, 0, 1));
        directed_rows.push_back(mk_fixed(CMD_CMP, 0, 0, 1, 2, 0, 0, 0, 1));
        directed_rows.push_back(mk_fixed(CMD_CMP, 1, 2, 0, 0, 0, 0, 0, 1));
        directed_rows.push_back(mk_fixed(CMD_CMP, 1, 2, 2, 4, 0, 0, 1, 0));
        directed_rows.push_back(mk_fixed(CMD_CMP, 1, -2, -1, 2, 0, 0, 0, 0));
        directed_rows.push_back(mk_fixed(CMD_ADD, 1, 2, 1, 2, 1, 1, 0, 0));
        directed_rows.push_back(mk_fixed(CMD_MUL, 2, 3, 3, 2, 1, 1, 0, 0));
        directed_rows.push_back(mk_fixed(CMD_MUL, 1, -1, 1, 1, 1, -1, 0, 0));
        directed_rows.push_back(mk_fixed(CMD_UNUSED, 7, 3, -5, 9, 0, 0, 0, 0));
        directed_rows.push_back(mk_fixed(CMD_UNUSED, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk(CMD_ADD, -32768, -32768, -32768, -32768));
        directed_rows.push_back(mk(CMD_ADD, -32768, 1, -32768, 1));
        directed_rows.push_back(mk(CMD_MUL, -32768, 1, -32768, 1));
        directed_rows.push_back(mk(CMD_ADD, 32767, -32768, 32767, 32767));
        directed_rows.push_back(mk(CMD_MUL, 32767, 32767, -32768, -32768));
        directed_rows.push_back(mk(CMD_CMP, -32768, 32767, -32768, 32767));
        directed_rows.push_back(mk(CMD_ADD, 0, -7, 0, 3));
        directed_rows.push_back(mk(CMD_ADD, 5, 0, 0, 0));
        directed_rows.push_back(mk(CMD_CMP, -1, -1, 1, 1));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k]) send_transaction(directed_rows[k]);

        for (int n = 0; n < 1400; n++) begin
            if (n == 467) begin
                tx_idle = 69;
                rx_idle = 38;
            end else if (n == 934) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            r = mk(($urandom_range(15) == 0) ? CMD_UNUSED : 2'($urandom_range(2)),
                   rand_operand(), rand_operand(), rand_operand(), rand_operand());
            if (r.cmd == CMD_CMP && $urandom_range(2) == 0) begin
                r.c = OPERAND_WIDTH'(r.a <<< 1);
                r.d = OPERAND_WIDTH'(r.b <<< 1);
            end
            send_transaction(r);
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/rmc_pkg.sv
hw/rtl/rmc_ctrl.sv
hw/rtl/rmc_dp.sv
hw/rtl/rational_add_mul_compare_unit.sv
tb/sv/tb_rational_add_mul_compare_unit.sv
